[design/arcl_pkg.sv]
// ============================================================================
// Arc length lookup package
// Types and constants shared by the arc length to parameter lookup block.
// ============================================================================
package arcl_pkg;

   // Fixed-point format of lengths and parameters, unsigned Q8.16.
   localparam int DATA_W  = 24;
   localparam int FRAC_W  = 16;
   localparam int INDEX_W = 7;
   localparam int COUNT_W = 8;

   // Request kinds carried on tuser.
   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // Configuration register indexes.
   typedef enum logic {
      CSR_ENTRY_COUNT  = 1'b0,
      CSR_TOTAL_LENGTH = 1'b1
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_WALK,
      ST_DIV,
      ST_MUL,
      ST_ADD,
      ST_RESP
   } state_type;

   // Start of a division: numerator is (s - s_i), denominator (s_i+1 - s_i).
   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] numer;
      logic [DATA_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] quot;
   } div_rsp_type;

endpackage

[design/arcl_ram.sv]
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module arcl_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/arcl_div.sv]
// ============================================================================
// Serial fraction divider
// Restoring division giving floor((numer << 16) / denom), one bit a cycle.
// ============================================================================
module arcl_div
   import arcl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(FRAC_W);

   logic              busy_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DATA_W-1:0] rem_ff;
   logic [DATA_W-1:0] den_ff;
   logic [FRAC_W-1:0] quot_ff;
   logic              done_ff;

   // The numerator is always below the denominator, so the shifted
   // remainder fits one extra bit and one trial subtract decides each bit.
   logic [DATA_W:0]   rem_shift;
   logic [DATA_W+1:0] trial;
   logic              take;

   assign rem_shift = {rem_ff, 1'b0};
   assign trial     = {1'b0, rem_shift} - {2'b00, den_ff};
   assign take      = !trial[DATA_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(FRAC_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= div_req.numer;
         den_ff <= div_req.denom;
      end else if (busy_ff) begin
         rem_ff  <= take ? trial[DATA_W-1:0] : rem_shift[DATA_W-1:0];
         quot_ff <= {quot_ff[FRAC_W-2:0], take};
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !div_req.start)
      else $error("division started while another was running");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && $past(busy_ff)) |-> (rem_ff < den_ff))
      else $error("divider remainder reached the denominator");
`endif

endmodule

[design/arc_length_to_parameter_lookup_top.sv]
// ============================================================================
// Arc length to curve parameter lookup
// Table of (parameter, cumulative length) pairs with a serial interval walk,
// a serial fraction divider and one interpolation multiply.
// ============================================================================
//
//   Channel  Direction  Contents
//   req_     in         tuser: opcode; tdata: entry_index, entry_param,
//                       entry_length, query_length
//   rsp_     out        tdata: param_value; tuser: in_range
//   csr_     in         write enable, register index, write data
//
// A write request completes without leaving the idle state. A query that
// finds its interval between entries i and i+1 (n = entries in use,
// i <= n - 2) primes the RAM read, walks at one table entry per cycle from
// the single RAM read port, runs the serial divider (sixteen quotient bits)
// and then passes through the multiply, add and response states; the response
// state holds until the output register is free. A query that finds no
// interval goes to the response state after the walk, or straight after the
// prime when fewer than two entries are in use. The next request is taken in
// the same cycle that the response is raised.
// Reset is synchronous and active high; it clears the sequencer, the
// configuration registers and the response valid, but not the working registers or the table contents.
// The block takes a new request while a finished response still waits in the
// output register; a later query then holds in its response state until the
// output register is free.
// ============================================================================
module arc_length_to_parameter_lookup_top
   import arcl_pkg::*;
#(
   parameter int TABLE_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // [6:0] entry_index, [30:7] entry_param, [54:31] entry_length,
   // [78:55] query_length, [79] zero
   input  logic [79:0] req_tdata,
   // [0] opcode
   input  logic [0:0]  req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [23:0] param_value
   output logic [23:0] rsp_tdata,
   // [0] in_range
   output logic [0:0]  rsp_tuser,
   // Configuration port.
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int LW    = $clog2(TABLE_DEPTH + 1);
   localparam int CW    = (LW > COUNT_W) ? LW : COUNT_W;
   localparam int ENT_W = 2 * DATA_W;
   localparam int PROD_W = FRAC_W + DATA_W + 2;

   // Request fields.
   logic [INDEX_W-1:0] req_index;
   logic [DATA_W-1:0]  req_param;
   logic [DATA_W-1:0]  req_length;
   logic [DATA_W-1:0]  req_query;
   op_type             req_op;
   logic               req_fire;

   assign req_index  = req_tdata[6:0];
   assign req_param  = req_tdata[30:7];
   assign req_length = req_tdata[54:31];
   assign req_query  = req_tdata[78:55];
   assign req_op     = op_type'(req_tuser[0]);

   // Configuration registers.
   logic [COUNT_W-1:0] entry_count_ff;
   logic [DATA_W-1:0]  total_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff  <= '0;
         total_length_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ENTRY_COUNT:  entry_count_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_TOTAL_LENGTH: total_length_ff <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // Sequencer state and working registers.
   state_type          state_ff, state_in;
   logic [LW-1:0]      k_ff;
   logic [LW-1:0]      limit_ff;
   logic [DATA_W-1:0]  s_ff;
   logic [DATA_W-1:0]  prev_len_ff;
   logic [DATA_W-1:0]  prev_par_ff;
   logic [DATA_W-1:0]  u0_ff;
   logic [DATA_W-1:0]  u1_ff;
   logic               found_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [DATA_W-1:0]  res_ff;

   logic               rsp_valid_ff;
   logic [DATA_W-1:0]  rsp_data_ff;
   logic               rsp_user_ff;

   // Table RAM; an entry holds the length in the low half, parameter above.
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [AW-1:0]      ram_raddr;
   logic [ENT_W-1:0]   ram_rdata;
   logic [DATA_W-1:0]  cur_len;
   logic [DATA_W-1:0]  cur_par;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // A write to a slot beyond the table is dropped.
   assign ram_we    = req_fire && (req_op == OP_WRITE) && (32'(req_index) < TABLE_DEPTH);
   assign ram_waddr = AW'(req_index);
   assign cur_len   = ram_rdata[DATA_W-1:0];
   assign cur_par   = ram_rdata[ENT_W-1:DATA_W];

   arcl_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data ({req_param, req_length}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Query setup: clamp the length and bound the walk by the table depth.
   logic [DATA_W-1:0] s_clamped;
   logic [CW-1:0]     count_ext;
   logic [CW-1:0]     count_lim;

   always_comb begin
      s_clamped = req_query;
      if (req_query > total_length_ff) begin
         s_clamped = (total_length_ff != '0) ? total_length_ff - 1'b1 : '0;
      end
      count_ext = CW'(entry_count_ff);
      count_lim = (count_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : count_ext;
   end

   // Interval test between the held entry i and the entry i+1 just read.
   logic hit;
   assign hit = (prev_len_ff <= s_ff) && (s_ff < cur_len);

   // Divider and interpolation.
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign div_req.start = (state_ff == ST_WALK) && hit;
   assign div_req.numer = s_ff - prev_len_ff;
   assign div_req.denom = cur_len - prev_len_ff;

   arcl_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   logic signed [DATA_W:0]   u_diff;
   logic signed [PROD_W-1:0] acc;

   assign u_diff = $signed({1'b0, u1_ff}) - $signed({1'b0, u0_ff});
   // u_i * 2^16 + alpha * (u_i+1 - u_i); never negative.
   assign acc    = $signed({2'b00, u0_ff, {FRAC_W{1'b0}}}) + prod_ff;

   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Next state and read address.
   always_comb begin
      state_in  = state_ff;
      ram_raddr = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_op == OP_QUERY)) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            ram_raddr = k_ff[AW-1:0];
            state_in  = (limit_ff < LW'(2)) ? ST_RESP : ST_WALK;
         end
         ST_WALK: begin
            ram_raddr = k_ff[AW-1:0];
            if (hit) begin
               state_in = ST_DIV;
            end else if (k_ff == limit_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_ADD;
         ST_ADD:  state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            s_ff     <= s_clamped;
            limit_ff <= LW'(count_lim);
            k_ff     <= LW'(1);
            found_ff <= 1'b0;
            res_ff   <= '0;
         end
         ST_PRIME: begin
            prev_len_ff <= cur_len;
            prev_par_ff <= cur_par;
            k_ff        <= k_ff + 1'b1;
         end
         ST_WALK: begin
            if (hit) begin
               u0_ff    <= prev_par_ff;
               u1_ff    <= cur_par;
               found_ff <= 1'b1;
            end else begin
               prev_len_ff <= cur_len;
               prev_par_ff <= cur_par;
               k_ff        <= k_ff + 1'b1;
            end
         end
         ST_MUL: prod_ff <= PROD_W'($signed({1'b0, div_rsp.quot})) * PROD_W'(u_diff);
         ST_ADD: res_ff  <= acc[FRAC_W+DATA_W-1:FRAC_W];
         default: ;
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_RESP) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_RESP) && rsp_free) begin
         rsp_data_ff <= found_ff ? res_ff : '0;
         rsp_user_ff <= found_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

`ifndef SYNTHESIS
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == OP_WRITE) && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("write request produced a response");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_user_ff) |-> (rsp_data_ff == '0))
      else $error("response without interval carries a nonzero parameter");

   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_interp_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |->
         ((acc[FRAC_W+DATA_W-1:FRAC_W] >= u0_ff && acc[FRAC_W+DATA_W-1:FRAC_W] <= u1_ff) ||
          (acc[FRAC_W+DATA_W-1:FRAC_W] <= u0_ff && acc[FRAC_W+DATA_W-1:FRAC_W] >= u1_ff)))
      else $error("interpolated parameter outside its interval");
`endif

endmodule
